// ===== rtl/power_energy_monitor_assert.svh =====
// Assertion macros for the power and energy monitor.
// Included by the top level; uses no other file.
`ifndef POWER_ENERGY_MONITOR_ASSERT_SVH
`define POWER_ENERGY_MONITOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PEM_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PEM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pem_pkg.sv =====
// Shared types and constants of the power and energy monitor.
// Used by the controller, the datapath and the top level; depends on nothing.
package pem_pkg;

   // Default field widths.
   localparam int SAMPLE_BITS_DEF   = 24;
   localparam int ELAPSED_BITS_DEF  = 16;
   localparam int RES_FRAC_BITS_DEF = 16;

   // Fixed widths of the resistance result and the accumulators.
   localparam int RES_BITS = 32;
   localparam int ACC_BITS = 64;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_PREP,
      S_RUN,
      S_SAT,
      S_APPLY
   } pem_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul;
      logic prep;
      logic sat;
      logic apply;
   } pem_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_busy;
      logic ser_busy;
   } pem_status_type;

endpackage

// ===== rtl/pem_divider.sv =====
// Restoring unsigned divider, one quotient bit per clock.
// Uses no package; instantiated by the datapath.
module pem_divider #(
   parameter int DIVIDEND_BITS = 40,
   parameter int DIVISOR_BITS  = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     busy,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  dsr_ff;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS+1:0]  diff;
   logic                     fits;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      shifted  = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      diff     = {1'b0, shifted} - {2'b00, dsr_ff};
      fits     = !diff[DIVISOR_BITS+1];
      rem_in   = fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
      quo_in   = {quo_ff[DIVIDEND_BITS-2:0], fits};
      count_in = count_ff - CNT_BITS'(1);
   end

   // Iteration counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start) begin
         count_ff <= CNT_BITS'(DIVIDEND_BITS);
      end else if (busy) begin
         count_ff <= count_in;
      end
   end

   // Remainder and quotient shift registers.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy     = (count_ff != '0);
   assign quotient = quo_ff;

endmodule

// ===== rtl/pem_ctrl.sv =====
// Controller state machine of the power and energy monitor.
// Depends on pem_pkg; drives the datapath commands and both handshakes.
module pem_ctrl
   import pem_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  pem_status_type status,
   output pem_cmd_type    cmd
);

   pem_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_RUN;
         end
         S_RUN: begin
            if (!status.div_busy && !status.ser_busy) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            cmd.sat  = 1'b1;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            // Wait until the previous result has left the output register.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.apply    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/pem_datapath.sv =====
// Datapath of the power and energy monitor: products, divider, statistics.
// Depends on pem_pkg and instantiates pem_divider.
module pem_datapath
   import pem_pkg::*;
#(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int ELAPSED_BITS  = ELAPSED_BITS_DEF,
   parameter int RES_FRAC_BITS = RES_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pem_cmd_type                     cmd,
   output pem_status_type                  status,
   input  logic signed [SAMPLE_BITS-1:0]   voltage,
   input  logic signed [SAMPLE_BITS-1:0]   current,
   input  logic [ELAPSED_BITS-1:0]         elapsed_ms,
   input  logic                            clear,
   output logic signed [RES_BITS-1:0]      resistance,
   output logic signed [2*SAMPLE_BITS-1:0] power,
   output logic signed [SAMPLE_BITS-1:0]   voltage_low,
   output logic signed [SAMPLE_BITS-1:0]   voltage_high,
   output logic signed [SAMPLE_BITS-1:0]   current_low,
   output logic signed [SAMPLE_BITS-1:0]   current_high,
   output logic signed [RES_BITS-1:0]      resistance_low,
   output logic signed [RES_BITS-1:0]      resistance_high,
   output logic signed [2*SAMPLE_BITS-1:0] power_low,
   output logic signed [2*SAMPLE_BITS-1:0] power_high,
   output logic signed [ACC_BITS-1:0]      charge_total,
   output logic signed [ACC_BITS-1:0]      energy_total
);

   localparam int SB   = SAMPLE_BITS;
   localparam int EB   = ELAPSED_BITS;
   localparam int PB   = 2 * SAMPLE_BITS;
   localparam int DW   = SAMPLE_BITS + RES_FRAC_BITS;
   localparam int QW   = (DW > RES_BITS + 1) ? DW : RES_BITS + 1;
   localparam int PEW  = PB + EB;
   localparam int EXW  = (PEW > ACC_BITS + 1) ? PEW : ACC_BITS + 1;
   localparam int ECW  = $clog2(EB + 1);

   localparam logic signed [SB-1:0]       S_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0]       S_MIN = {1'b1, {(SB-1){1'b0}}};
   localparam logic signed [RES_BITS-1:0] R_MAX = {1'b0, {(RES_BITS-1){1'b1}}};
   localparam logic signed [RES_BITS-1:0] R_MIN = {1'b1, {(RES_BITS-1){1'b0}}};
   localparam logic signed [PB-1:0]       P_MAX = {1'b0, {(PB-1){1'b1}}};
   localparam logic signed [PB-1:0]       P_MIN = {1'b1, {(PB-1){1'b0}}};
   localparam logic signed [ACC_BITS-1:0] A_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] A_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   // Saturating signed add of two accumulator-wide values.
   function automatic logic signed [ACC_BITS-1:0] sat_add(
      input logic signed [ACC_BITS-1:0] a,
      input logic signed [ACC_BITS-1:0] b
   );
      logic signed [ACC_BITS-1:0] sum;
      sum = a + b;
      if ((a[ACC_BITS-1] == b[ACC_BITS-1]) && (sum[ACC_BITS-1] != a[ACC_BITS-1])) begin
         return a[ACC_BITS-1] ? A_MIN : A_MAX;
      end
      return sum;
   endfunction

   // Captured request.
   logic signed [SB-1:0] v_ff, c_ff;
   logic [EB-1:0]        ms_ff;
   logic                 clr_ff;

   // Products and terms.
   logic signed [PB-1:0]       pw_ff;
   logic signed [SB+EB:0]      cprod;
   logic signed [ACC_BITS-1:0] cterm_ff;
   logic [PB-1:0]              pmag_ff;
   logic                       pneg_ff;
   logic [PEW-1:0]             eacc_ff;
   logic [EB-1:0]              msh_ff;
   logic [ECW-1:0]             ecnt_ff;
   logic signed [ACC_BITS-1:0] eterm_ff, eterm_in;
   logic signed [RES_BITS-1:0] res_ff, res_in;

   // Divider interface.
   logic [SB-1:0] vmag, cmag;
   logic [DW-1:0] quotient;
   logic          div_busy;

   // Saturation helpers.
   logic [QW-1:0]  qext;
   logic [EXW-1:0] eext;
   logic           rneg;

   // Statistics and output registers.
   logic signed [SB-1:0]       vmin_ff, vmax_ff, cmin_ff, cmax_ff;
   logic signed [RES_BITS-1:0] rmin_ff, rmax_ff, rsp_res_ff;
   logic signed [PB-1:0]       pmin_ff, pmax_ff, rsp_pw_ff;
   logic signed [ACC_BITS-1:0] charge_ff, energy_ff;

   // Base values after an optional clear.
   logic signed [SB-1:0]       vmin_b, vmax_b, cmin_b, cmax_b;
   logic signed [RES_BITS-1:0] rmin_b, rmax_b;
   logic signed [PB-1:0]       pmin_b, pmax_b;
   logic signed [ACC_BITS-1:0] charge_b, energy_b;

   // Capture the request.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         v_ff   <= voltage;
         c_ff   <= current;
         ms_ff  <= elapsed_ms;
         clr_ff <= clear;
      end
   end

   // Power and charge term, one multiplier each.
   assign cprod = c_ff * $signed({1'b0, ms_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         pw_ff    <= v_ff * c_ff;
         cterm_ff <= ACC_BITS'(cprod);
      end
   end

   // Magnitudes for the divider, which starts with the multipliers.
   assign vmag = v_ff[SB-1] ? SB'(-v_ff) : SB'(v_ff);
   assign cmag = c_ff[SB-1] ? SB'(-c_ff) : SB'(c_ff);

   pem_divider #(
      .DIVIDEND_BITS (DW),
      .DIVISOR_BITS  (SB)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mul),
      .dividend (DW'(vmag) << RES_FRAC_BITS),
      .divisor  (cmag),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Energy term: power magnitude times elapsed time, one bit of time per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         ecnt_ff <= '0;
      end else if (cmd.prep) begin
         ecnt_ff <= ECW'(EB);
      end else if (ecnt_ff != '0) begin
         ecnt_ff <= ecnt_ff - ECW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         pmag_ff <= pw_ff[PB-1] ? PB'(-pw_ff) : PB'(pw_ff);
         pneg_ff <= pw_ff[PB-1];
         eacc_ff <= '0;
         msh_ff  <= ms_ff;
      end else if (ecnt_ff != '0) begin
         eacc_ff <= (eacc_ff << 1) + (msh_ff[EB-1] ? PEW'(pmag_ff) : '0);
         msh_ff  <= msh_ff << 1;
      end
   end

   assign status.div_busy = div_busy;
   assign status.ser_busy = (ecnt_ff != '0);

   // Signed saturation of the quotient and the energy term.
   always_comb begin
      rneg = v_ff[SB-1] ^ c_ff[SB-1];
      qext = QW'(quotient);
      if (c_ff == '0) begin
         res_in = R_MAX;
      end else if (!rneg && (qext > QW'(R_MAX))) begin
         res_in = R_MAX;
      end else if (rneg && (qext > QW'({1'b0, R_MIN}))) begin
         res_in = R_MIN;
      end else if (rneg) begin
         res_in = -$signed(qext[RES_BITS-1:0]);
      end else begin
         res_in = $signed(qext[RES_BITS-1:0]);
      end

      eext = EXW'(eacc_ff);
      if (!pneg_ff && (eext > EXW'({1'b0, A_MAX}))) begin
         eterm_in = A_MAX;
      end else if (pneg_ff && (eext > EXW'({1'b0, A_MIN}))) begin
         eterm_in = A_MIN;
      end else if (pneg_ff) begin
         eterm_in = -$signed(eext[ACC_BITS-1:0]);
      end else begin
         eterm_in = $signed(eext[ACC_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sat) begin
         res_ff   <= res_in;
         eterm_ff <= eterm_in;
      end
   end

   // Statistics start from their cleared values when the request asks for it.
   always_comb begin
      vmin_b   = clr_ff ? S_MAX : vmin_ff;
      vmax_b   = clr_ff ? S_MIN : vmax_ff;
      cmin_b   = clr_ff ? S_MAX : cmin_ff;
      cmax_b   = clr_ff ? S_MIN : cmax_ff;
      rmin_b   = clr_ff ? R_MAX : rmin_ff;
      rmax_b   = clr_ff ? R_MIN : rmax_ff;
      pmin_b   = clr_ff ? P_MAX : pmin_ff;
      pmax_b   = clr_ff ? P_MIN : pmax_ff;
      charge_b = clr_ff ? '0 : charge_ff;
      energy_b = clr_ff ? '0 : energy_ff;
   end

   // Apply the sample to the statistics and accumulators.
   always_ff @(posedge clock) begin
      if (reset) begin
         vmin_ff   <= S_MAX;
         vmax_ff   <= S_MIN;
         cmin_ff   <= S_MAX;
         cmax_ff   <= S_MIN;
         rmin_ff   <= R_MAX;
         rmax_ff   <= R_MIN;
         pmin_ff   <= P_MAX;
         pmax_ff   <= P_MIN;
         charge_ff <= '0;
         energy_ff <= '0;
      end else if (cmd.apply) begin
         vmin_ff   <= (v_ff < vmin_b) ? v_ff : vmin_b;
         vmax_ff   <= (v_ff > vmax_b) ? v_ff : vmax_b;
         cmin_ff   <= (c_ff < cmin_b) ? c_ff : cmin_b;
         cmax_ff   <= (c_ff > cmax_b) ? c_ff : cmax_b;
         rmin_ff   <= (res_ff < rmin_b) ? res_ff : rmin_b;
         rmax_ff   <= (res_ff > rmax_b) ? res_ff : rmax_b;
         pmin_ff   <= (pw_ff < pmin_b) ? pw_ff : pmin_b;
         pmax_ff   <= (pw_ff > pmax_b) ? pw_ff : pmax_b;
         charge_ff <= sat_add(charge_b, cterm_ff);
         energy_ff <= sat_add(energy_b, eterm_ff);
      end
   end

   // Per-sample results held for the output channel.
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_res_ff <= res_ff;
         rsp_pw_ff  <= pw_ff;
      end
   end

   assign resistance      = rsp_res_ff;
   assign power           = rsp_pw_ff;
   assign voltage_low     = vmin_ff;
   assign voltage_high    = vmax_ff;
   assign current_low     = cmin_ff;
   assign current_high    = cmax_ff;
   assign resistance_low  = rmin_ff;
   assign resistance_high = rmax_ff;
   assign power_low       = pmin_ff;
   assign power_high      = pmax_ff;
   assign charge_total    = charge_ff;
   assign energy_total    = energy_ff;

endmodule

// ===== rtl/power_energy_monitor.sv =====
// From request to result: capture, multiply with divider start, energy-term setup, wait
// for the divider (one quotient bit per cycle) and the serial energy term, saturate, and
// apply once the output register is free. Requests are taken one at a time, in the idle
// state only; a new request is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) clears min/max to their extremes and the
// accumulators to zero; no clearing pass is needed.
`include "power_energy_monitor_assert.svh"

// Top level of the power and energy monitor.
// Depends on pem_pkg, pem_ctrl, pem_datapath and the assertion header.
module power_energy_monitor
   import pem_pkg::*;
#(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int ELAPSED_BITS  = ELAPSED_BITS_DEF,
   parameter int RES_FRAC_BITS = RES_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // voltage, current, elapsed_ms, zero padding
   input  logic [((2*SAMPLE_BITS+ELAPSED_BITS+7)/8)*8-1:0] req_tdata,
   // clear
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // resistance, power, voltage_low, voltage_high, current_low, current_high,
   // resistance_low, resistance_high, power_low, power_high, charge_total,
   // energy_total, zero padding
   output logic [((10*SAMPLE_BITS+224+7)/8)*8-1:0] rsp_tdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int EB    = ELAPSED_BITS;
   localparam int PB    = 2 * SAMPLE_BITS;
   localparam int RSP_W = ((10*SAMPLE_BITS+224+7)/8)*8;

   pem_cmd_type    cmd;
   pem_status_type status;

   logic signed [RES_BITS-1:0] resistance, resistance_low, resistance_high;
   logic signed [PB-1:0]       power, power_low, power_high;
   logic signed [SB-1:0]       voltage_low, voltage_high, current_low, current_high;
   logic signed [ACC_BITS-1:0] charge_total, energy_total;

   pem_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pem_datapath #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .ELAPSED_BITS  (ELAPSED_BITS),
      .RES_FRAC_BITS (RES_FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .voltage         ($signed(req_tdata[SB-1:0])),
      .current         ($signed(req_tdata[2*SB-1:SB])),
      .elapsed_ms      (req_tdata[2*SB+EB-1:2*SB]),
      .clear           (req_tuser),
      .resistance      (resistance),
      .power           (power),
      .voltage_low     (voltage_low),
      .voltage_high    (voltage_high),
      .current_low     (current_low),
      .current_high    (current_high),
      .resistance_low  (resistance_low),
      .resistance_high (resistance_high),
      .power_low       (power_low),
      .power_high      (power_high),
      .charge_total    (charge_total),
      .energy_total    (energy_total)
   );

   // Pack the result fields, first field in the lowest bits.
   assign rsp_tdata = RSP_W'({energy_total, charge_total, power_high, power_low,
                              resistance_high, resistance_low, current_high,
                              current_low, voltage_high, voltage_low,
                              power, resistance});

   // The output register is never loaded while it still holds an untaken result.
   `PEM_ASSERT_IMPL(a_no_overwrite, cmd.apply, (!rsp_tvalid || rsp_tready), "result overwritten")
   // The divider is running right after the multiply step.
   `PEM_ASSERT_NEXT(a_div_started, cmd.mul, status.div_busy, "divider did not start")
   // Saturation only samples finished divider and energy results.
   `PEM_ASSERT_IMPL(a_sat_done, cmd.sat, (!status.div_busy && !status.ser_busy), "early saturation")

endmodule
